/* rtl/pfds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfds_pkg
// Shared constants and types for the prime-first descending sort block.
// ----------------------------------------------------------------------------
package pfds_pkg;

	localparam int VALUE_W    = 10;
	localparam int POS_W      = 6;
	localparam int SIDE_DEF   = 8;
	localparam int STORE_DEPTH = 64;

	// classified item handed from the front part to the back part
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               prime;
	} class_item_t;

endpackage
`default_nettype wire

/* rtl/pfds_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfds_classify
// Front part: takes one value at a time and tests it for primality by
// trial division, one divisor per modulo pass, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfds_classify (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire  [pfds_pkg::VALUE_W-1:0] sample_value,
	output logic                         cls_valid,
	input  wire                          cls_ready,
	output pfds_pkg::class_item_t        cls_item
);
	import pfds_pkg::*;

	localparam int CNT_W = $clog2(VALUE_W + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] div_q;
	logic [VALUE_W-1:0] rem_q;
	logic [CNT_W-1:0]   bit_q;
	logic               prime_q;
	logic [VALUE_W:0]   trial;

	assign full      = (state_q != ST_IDLE);
	assign cls_valid = (state_q == ST_OUT);
	assign cls_item  = '{value: value_q, prime: prime_q};

	// restoring remainder step, dividend bits msb first
	assign trial = {rem_q, value_q[bit_q[CNT_W-1:0] - CNT_W'(1)]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			value_q <= '0;
			div_q   <= '0;
			rem_q   <= '0;
			bit_q   <= '0;
			prime_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (push) begin
						value_q <= sample_value;
						div_q   <= VALUE_W'(2);
						rem_q   <= '0;
						bit_q   <= CNT_W'(VALUE_W);
						if (sample_value < VALUE_W'(2)) begin
							prime_q <= 1'b0;
							state_q <= ST_OUT;
						end else if (sample_value < VALUE_W'(4)) begin
							prime_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							prime_q <= 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (trial >= {1'b0, div_q}) begin
						rem_q <= VALUE_W'(trial - {1'b0, div_q});
					end else begin
						rem_q <= trial[VALUE_W-1:0];
					end
					bit_q <= bit_q - CNT_W'(1);
					if (bit_q == CNT_W'(1)) begin
						// remainder of this divisor is ready
						if (((trial >= {1'b0, div_q}) ?
							VALUE_W'(trial - {1'b0, div_q}) : trial[VALUE_W-1:0]) == '0) begin
							prime_q <= 1'b0;
							state_q <= ST_OUT;
						end else if (div_q + VALUE_W'(1) > (value_q >> 1)) begin
							state_q <= ST_OUT;
						end else begin
							div_q <= div_q + VALUE_W'(1);
							rem_q <= '0;
							bit_q <= CNT_W'(VALUE_W);
						end
					end
				end
				ST_OUT: begin
					if (cls_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/pfds_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfds_queue
// Two-entry queue between the classifier and the sorter.
// ----------------------------------------------------------------------------
module pfds_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  pfds_pkg::class_item_t in_item,
	output logic                  out_valid,
	input  wire                   out_ready,
	output pfds_pkg::class_item_t out_item
);
	import pfds_pkg::*;

	class_item_t slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        do_wr;
	logic        do_rd;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = slot_q[rd_q];
	assign do_wr     = in_valid && in_ready;
	assign do_rd     = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wr_q <= ~wr_q;
			if (do_rd) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

endmodule
`default_nettype wire

/* rtl/pfds_sorter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfds_sorter
// Back part: collects a block of classified values, then repeatedly scans
// the store for the largest remaining value of the current group and emits
// it, primes first. Each store entry is read in ST_SCAN and compared in ST_WAIT.
// ----------------------------------------------------------------------------
module pfds_sorter #(
	parameter int SIDE = pfds_pkg::SIDE_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  pfds_pkg::class_item_t        in_item,
	output logic                         empty,
	input  wire                          pop,
	output logic [pfds_pkg::VALUE_W-1:0] sorted_value,
	output logic                         is_prime,
	output logic [pfds_pkg::POS_W-1:0]   position,
	output logic                         final_item
);
	import pfds_pkg::*;

	localparam int BLOCK_LEN = SIDE * SIDE;
	localparam int IDX_W     = $clog2(BLOCK_LEN);
	localparam int CNT_W     = $clog2(BLOCK_LEN + 1);

	typedef enum logic [2:0] {ST_LOAD, ST_SCAN, ST_WAIT, ST_PICK, ST_EMIT} state_t;

	// memory with a used bit per entry kept alongside
	logic [VALUE_W:0]   mem [BLOCK_LEN];
	logic [VALUE_W:0]   rd_data_q;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   emitted_q;
	logic [CNT_W-1:0]   scan_q;
	logic               group_q;
	logic               found_q;
	logic [VALUE_W-1:0] best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [IDX_W-1:0]   rd_idx;
	logic               used_q [BLOCK_LEN];
	logic               rd_used_q;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [VALUE_W:0]   wr_data;

	assign in_ready = (state_q == ST_LOAD);
	assign empty    = (state_q != ST_EMIT);
	assign rd_idx   = scan_q[IDX_W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = count_q[IDX_W-1:0];
		wr_data = {in_item.prime, in_item.value};
		if (state_q == ST_LOAD && in_valid) begin
			wr_en = 1'b1;
		end
	end

	// used bits are cleared as each entry is loaded
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx]    <= wr_data;
			used_q[wr_idx] <= 1'b0;
		end else if (state_q == ST_EMIT && pop) begin
			used_q[best_idx_q] <= 1'b1;
		end
		rd_data_q <= mem[rd_idx];
		rd_used_q <= used_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			count_q      <= '0;
			emitted_q    <= '0;
			scan_q       <= '0;
			group_q      <= 1'b1;
			found_q      <= 1'b0;
			best_q       <= '0;
			best_idx_q   <= '0;
			sorted_value <= '0;
			is_prime     <= 1'b0;
			position     <= '0;
			final_item   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (count_q == CNT_W'(BLOCK_LEN - 1)) begin
							count_q   <= '0;
							emitted_q <= '0;
							group_q   <= 1'b1;
							scan_q    <= '0;
							found_q   <= 1'b0;
							state_q   <= ST_SCAN;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					// read issued for scan_q, data arrives next cycle
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!rd_used_q && rd_data_q[VALUE_W] == group_q &&
						(!found_q || rd_data_q[VALUE_W-1:0] > best_q)) begin
						found_q    <= 1'b1;
						best_q     <= rd_data_q[VALUE_W-1:0];
						best_idx_q <= rd_idx;
					end
					if (scan_q == CNT_W'(BLOCK_LEN - 1)) begin
						state_q <= ST_PICK;
					end else begin
						scan_q  <= scan_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_PICK: begin
					scan_q <= '0;
					if (found_q) begin
						sorted_value <= best_q;
						is_prime     <= group_q;
						position     <= POS_W'(emitted_q);
						final_item   <= (emitted_q == CNT_W'(BLOCK_LEN - 1));
						state_q      <= ST_EMIT;
					end else begin
						// primes exhausted, move to the other group
						group_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (pop) begin
						found_q <= 1'b0;
						scan_q  <= '0;
						if (emitted_q == CNT_W'(BLOCK_LEN - 1)) begin
							state_q <= ST_LOAD;
						end else begin
							emitted_q <= emitted_q + CNT_W'(1);
							state_q   <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/prime_first_descending_sort_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prime_first_descending_sort_unit
// Takes a block of SIDE*SIDE values and returns them primes first, each
// group in descending order, with position and a last-item marker.
//
// Input side: push/full, one value per item, row-major order. The
// classifier tests each value by trial division, one quotient bit per
// cycle, over the divisors from 2 up to half the value, stopping at the
// first that divides it; values below 4 skip the division.
// A two-entry queue lets the classifier run ahead of the sorter.
// Result side: empty/pop. Once the block is complete the sorter emits
// SIDE*SIDE results; each takes a full scan of the store, in which every
// entry is read and then compared, and a second scan when the primes
// run out. While the receiver stalls the current result holds and no new
// block is loaded; up to three further items are taken in before full
// stays high. Reset empties everything and a new block starts.
// ----------------------------------------------------------------------------
module prime_first_descending_sort_unit #(
	parameter int SIDE = pfds_pkg::SIDE_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire  [pfds_pkg::VALUE_W-1:0] sample_value,
	output logic                         empty,
	input  wire                          pop,
	output logic [pfds_pkg::VALUE_W-1:0] sorted_value,
	output logic                         is_prime,
	output logic [pfds_pkg::POS_W-1:0]   position,
	output logic                         final_item
);
	import pfds_pkg::*;

	logic        cls_valid;
	logic        cls_ready;
	class_item_t cls_item;
	logic        q_valid;
	logic        q_ready;
	class_item_t q_item;

	pfds_classify u_classify (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_value (sample_value),
		.cls_valid    (cls_valid),
		.cls_ready    (cls_ready),
		.cls_item     (cls_item)
	);

	pfds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cls_valid),
		.in_ready  (cls_ready),
		.in_item   (cls_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	pfds_sorter #(.SIDE(SIDE)) u_sorter (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (q_valid),
		.in_ready     (q_ready),
		.in_item      (q_item),
		.empty        (empty),
		.pop          (pop),
		.sorted_value (sorted_value),
		.is_prime     (is_prime),
		.position     (position),
		.final_item   (final_item)
	);

endmodule
`default_nettype wire
